>>> src/esp_pkg.sv
// Shared types, constants and a helper function for the ellipsoid surface point datapath.
package esp_pkg;

  // Field widths
  localparam int ANGLE_W  = 32;
  localparam int RADIUS_W = 33;
  localparam int COORD_W  = 34;
  localparam int CORD_W   = 34;   // CORDIC x, y, z in Q2.30 with headroom
  localparam int MAG_W    = 31;   // magnitude of a clamped sine or cosine
  localparam int PROD_W   = 64;   // radius times trig magnitude
  localparam int RAD_W    = 128;  // sum of squares
  localparam int ROOT_W   = 64;
  localparam int FRAC_SH  = 46;
  localparam int NUM_W    = 2 * RADIUS_W + FRAC_SH;  // a*b scaled by 2^46
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SIDE_W   = 4 * MAG_W + 3;
  localparam int SROOT_REM_W = ROOT_W + 4;

  // Angle constants, Q3.28
  localparam logic signed [CORD_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [CORD_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [CORD_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  // CORDIC constants, Q2.30
  localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032875;
  localparam logic signed [CORD_W-1:0] ONE_Q30  = 34'sd1073741824;

  // Register map (index = paddr[3])
  localparam logic REG_EQUATORIAL = 1'b0;
  localparam logic REG_POLAR      = 1'b1;
  localparam logic [RADIUS_W-1:0] EQUATORIAL_RESET = 33'd6378137000;
  localparam logic [RADIUS_W-1:0] POLAR_RESET      = 33'd6356752314;

  // One angle in flight through the CORDIC row
  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic                     neg;
  } cordic_t;

  // Longitude and latitude rotate side by side
  typedef struct packed {
    cordic_t lon;
    cordic_t lat;
  } cordic_pair_t;

  // Square root cell contents
  typedef struct packed {
    logic [RAD_W-1:0]       rad;
    logic [SROOT_REM_W-1:0] rem;
    logic [ROOT_W-1:0]      root;
    logic [SIDE_W-1:0]      side;
  } sqrt_t;

  // Divider cell contents; num turns into the quotient as it shifts
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] den;
    logic [SIDE_W-1:0] side;
  } div_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [CORD_W-1:0] atan_step(input int i);
    logic signed [CORD_W-1:0] s;
    case (i)
      0:  s = 34'sd843314857;
      1:  s = 34'sd497837829;
      2:  s = 34'sd263043837;
      3:  s = 34'sd133525159;
      4:  s = 34'sd67021687;
      5:  s = 34'sd33543516;
      6:  s = 34'sd16775851;
      7:  s = 34'sd8388437;
      8:  s = 34'sd4194283;
      9:  s = 34'sd2097149;
      10: s = 34'sd1048576;
      default: begin
        if (i <= 30) s = 34'sd1 <<< (30 - i);
        else s = '0;
      end
    endcase
    return s;
  endfunction

endpackage

>>> src/esp_cordic_cell.sv
// One rotation step of the sine/cosine CORDIC row, both angles at once.
module esp_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  esp_pkg::cordic_pair_t in_data,
  output logic                  out_valid,
  output esp_pkg::cordic_pair_t out_data
);

  localparam logic signed [esp_pkg::CORD_W-1:0] STEP = esp_pkg::atan_step(ITER);

  function automatic esp_pkg::cordic_t rotate(input esp_pkg::cordic_t c);
    esp_pkg::cordic_t r;
    logic signed [esp_pkg::CORD_W-1:0] dx;
    logic signed [esp_pkg::CORD_W-1:0] dy;
    dx = c.y >>> ITER;
    dy = c.x >>> ITER;
    r = c;
    if (!c.z[esp_pkg::CORD_W-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - STEP;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + STEP;
    end
    return r;
  endfunction

  esp_pkg::cordic_pair_t data_next;

  always_comb begin
    data_next.lon = rotate(in_data.lon);
    data_next.lat = rotate(in_data.lat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/esp_sqrt_cell.sv
// One result bit of the restoring square root row.
module esp_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  esp_pkg::sqrt_t in_data,
  output logic           out_valid,
  output esp_pkg::sqrt_t out_data
);

  localparam int RW = esp_pkg::SROOT_REM_W;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;
  esp_pkg::sqrt_t data_next;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {in_data.rem[RW-3:0], in_data.rad[esp_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, in_data.root, 2'b01};
    ge     = (rem_sh >= trial);
    data_next      = in_data;
    data_next.rad  = {in_data.rad[esp_pkg::RAD_W-3:0], 2'b00};
    data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
    data_next.root = {in_data.root[esp_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/esp_div_cell.sv
// One quotient bit of the restoring divider row.
module esp_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  esp_pkg::div_t in_data,
  output logic          out_valid,
  output esp_pkg::div_t out_data
);

  localparam int DW = esp_pkg::ROOT_W;

  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;
  esp_pkg::div_t data_next;

  // shift in one numerator bit, subtract divisor when it fits
  always_comb begin
    rem_sh = {in_data.rem, in_data.num[esp_pkg::NUM_W-1]};
    diff   = rem_sh - {1'b0, in_data.den};
    ge     = (rem_sh >= {1'b0, in_data.den});
    data_next     = in_data;
    data_next.rem = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    data_next.num = {in_data.num[esp_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/ellipsoid_surface_point_unit.sv
// Top level: ellipsoid surface point from longitude and geocentric latitude.
//
// Input stream (s_*): one transfer carries a longitude and a latitude, both
// signed Q3.28 radians. Output stream (m_*): one transfer per input with the
// x, y and z coordinates of the surface point in signed millimetres,
// saturated to 34 bits. Results leave in input order.
// APB port: register 0 (address 0x0) is the equatorial radius, register 1
// (address 0x8) the polar radius, 33-bit millimetres. Write them only while
// no transfer is in flight.
// Path from an input transfer to m_tvalid: one CORDIC cell per iteration,
// a 64-cell square root row, a 112-cell divider row, nine multiply and
// format stages and the output register.
// Throughput: one transfer per cycle while the output does not hold the
// pipeline frozen; every cell of every row hands its item to the next
// cell each cycle that the pipeline moves.
// Reset clears all valid flags and loads the WGS84 radii.
// When m_tready is low the finished result waits in the output register and
// the rows keep moving until the last stage also holds a result; only then
// does the whole pipeline freeze and s_tready drop.
module ellipsoid_surface_point_unit #(
  parameter int CORDIC_ITERATIONS = 28
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [31:0] longitude_rad, [63:32] latitude_rad
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [33:0] point_x_mm, [67:34] point_y_mm,
                                  // [101:68] point_z_mm, [103:102] zero
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int NC = CORDIC_ITERATIONS;
  localparam int CW = esp_pkg::CORD_W;
  localparam int MW = esp_pkg::MAG_W;
  localparam int SW = esp_pkg::SIDE_W;
  localparam int RW = esp_pkg::RADIUS_W;

  // ---------------- configuration ----------------
  logic [RW-1:0]   equatorial;
  logic [RW-1:0]   polar;
  logic [2*RW-1:0] ab;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      equatorial <= esp_pkg::EQUATORIAL_RESET;
      polar      <= esp_pkg::POLAR_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        esp_pkg::REG_EQUATORIAL: equatorial <= pwdata[RW-1:0];
        esp_pkg::REG_POLAR:      polar      <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      esp_pkg::REG_EQUATORIAL: prdata = {{(64-RW){1'b0}}, equatorial};
      esp_pkg::REG_POLAR:      prdata = {{(64-RW){1'b0}}, polar};
      default:                 prdata = '0;
    endcase
  end

  // product of radii, static between writes
  always_ff @(posedge clk) begin
    ab <= equatorial * polar;
  end

  // ---------------- flow control ----------------
  logic lst_valid;
  logic en;

  assign en       = !(lst_valid && m_tvalid && !m_tready);
  assign s_tready = en;

  // ---------------- angle reduction ----------------
  function automatic esp_pkg::cordic_t reduce(input logic [31:0] ang);
    esp_pkg::cordic_t c;
    logic signed [CW-1:0] z;
    z = CW'(signed'(ang));
    c.neg = 1'b0;
    if (z > esp_pkg::PI_Q28) z = z - esp_pkg::TWO_PI_Q28;
    else if (z < -esp_pkg::PI_Q28) z = z + esp_pkg::TWO_PI_Q28;
    if (z > esp_pkg::HALF_PI_Q28) begin
      z = z - esp_pkg::PI_Q28;
      c.neg = 1'b1;
    end else if (z < -esp_pkg::HALF_PI_Q28) begin
      z = z + esp_pkg::PI_Q28;
      c.neg = 1'b1;
    end
    c.x = esp_pkg::GAIN_Q30;
    c.y = '0;
    c.z = z <<< 2;
    return c;
  endfunction

  // ---------------- CORDIC row ----------------
  logic                  cv [0:NC];
  esp_pkg::cordic_pair_t cd [0:NC];

  assign cv[0]     = s_tvalid;
  assign cd[0].lon = reduce(s_tdata[31:0]);
  assign cd[0].lat = reduce(s_tdata[63:32]);

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    esp_cordic_cell #(.ITER(g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[g]), .in_data(cd[g]),
      .out_valid(cv[g+1]), .out_data(cd[g+1])
    );
  end

  // clamp to unit range and apply half-turn negation
  function automatic logic signed [31:0] unit(input logic signed [CW-1:0] v, input logic neg);
    logic signed [CW-1:0] c;
    if (v > esp_pkg::ONE_Q30) c = esp_pkg::ONE_Q30;
    else if (v < -esp_pkg::ONE_Q30) c = -esp_pkg::ONE_Q30;
    else c = v;
    if (neg) c = -c;
    return c[31:0];
  endfunction

  function automatic logic [MW-1:0] magn(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return m[MW-1:0];
  endfunction

  // ---------------- P1: trig magnitudes and signs ----------------
  logic signed [31:0] ca, sa, cb, sb;
  logic          p1_valid;
  logic [MW-1:0] p1_ca, p1_sa, p1_cb, p1_sb;
  logic          p1_sx, p1_sy, p1_sz;

  always_comb begin
    ca = unit(cd[NC].lon.x, cd[NC].lon.neg);
    sa = unit(cd[NC].lon.y, cd[NC].lon.neg);
    cb = unit(cd[NC].lat.x, cd[NC].lat.neg);
    sb = unit(cd[NC].lat.y, cd[NC].lat.neg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ca <= magn(ca);
      p1_sa <= magn(sa);
      p1_cb <= magn(cb);
      p1_sb <= magn(sb);
      p1_sx <= ca[31] ^ cb[31];
      p1_sy <= sa[31] ^ cb[31];
      p1_sz <= sb[31];
    end
  end

  logic [SW-1:0] p1_side;
  assign p1_side = {p1_ca, p1_sa, p1_cb, p1_sb, p1_sx, p1_sy, p1_sz};

  // ---------------- P2: b|cosB| and a|sinB| ----------------
  logic          p2_valid;
  logic [63:0]   p2_bc, p2_as;
  logic [SW-1:0] p2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_bc   <= polar * p1_cb;
      p2_as   <= equatorial * p1_sb;
      p2_side <= p1_side;
    end
  end

  // ---------------- P3: partial products of the squares ----------------
  logic          p3_valid;
  logic [63:0]   p3_bll, p3_blh, p3_bhh, p3_all, p3_alh, p3_ahh;
  logic [SW-1:0] p3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_bll  <= p2_bc[31:0] * p2_bc[31:0];
      p3_blh  <= p2_bc[31:0] * p2_bc[63:32];
      p3_bhh  <= p2_bc[63:32] * p2_bc[63:32];
      p3_all  <= p2_as[31:0] * p2_as[31:0];
      p3_alh  <= p2_as[31:0] * p2_as[63:32];
      p3_ahh  <= p2_as[63:32] * p2_as[63:32];
      p3_side <= p2_side;
    end
  end

  // ---------------- P4: sum of squares ----------------
  logic          p4_valid;
  logic [127:0]  p4_rad;
  logic [SW-1:0] p4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_rad <= (128'(p3_bhh) << 64) + (128'(p3_blh) << 33) + 128'(p3_bll)
              + (128'(p3_ahh) << 64) + (128'(p3_alh) << 33) + 128'(p3_all);
      p4_side <= p3_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= cv[NC];
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // ---------------- square root row ----------------
  logic           sv [0:esp_pkg::SQRT_STEPS];
  esp_pkg::sqrt_t sd [0:esp_pkg::SQRT_STEPS];

  assign sv[0] = p4_valid;
  always_comb begin
    sd[0].rad  = p4_rad;
    sd[0].rem  = '0;
    sd[0].root = '0;
    sd[0].side = p4_side;
  end

  for (genvar g = 0; g < esp_pkg::SQRT_STEPS; g++) begin : g_sqrt
    esp_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[g]), .in_data(sd[g]),
      .out_valid(sv[g+1]), .out_data(sd[g+1])
    );
  end

  // ---------------- divider row ----------------
  logic          dv [0:esp_pkg::DIV_STEPS];
  esp_pkg::div_t dd [0:esp_pkg::DIV_STEPS];

  assign dv[0] = sv[esp_pkg::SQRT_STEPS];
  always_comb begin
    dd[0].num  = {ab, {esp_pkg::FRAC_SH{1'b0}}};
    dd[0].rem  = '0;
    dd[0].den  = sd[esp_pkg::SQRT_STEPS].root;
    dd[0].side = sd[esp_pkg::SQRT_STEPS].side;
  end

  for (genvar g = 0; g < esp_pkg::DIV_STEPS; g++) begin : g_div
    esp_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[g]), .in_data(dd[g]),
      .out_valid(dv[g+1]), .out_data(dd[g+1])
    );
  end

  // ---------------- P5: radius with zero-divisor and overflow handling ----------------
  esp_pkg::div_t dq;
  logic          p5_valid;
  logic [63:0]   p5_r;
  logic [SW-1:0] p5_side;

  assign dq = dd[esp_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (dq.den == '0) p5_r <= '0;
      else if (dq.num[esp_pkg::NUM_W-1:64] != '0) p5_r <= '1;
      else p5_r <= dq.num[63:0];
      p5_side <= dq.side;
    end
  end

  // side fields
  logic [MW-1:0] s5_ca, s5_sa, s5_cb, s5_sb;
  logic          s5_sx, s5_sy, s5_sz;
  assign {s5_ca, s5_sa, s5_cb, s5_sb, s5_sx, s5_sy, s5_sz} = p5_side;

  // ---------------- P6: R*|cosB| and R*|sinB| partial products ----------------
  logic          p6_valid;
  logic [62:0]   p6_cl, p6_ch, p6_sl, p6_sh;
  logic [MW-1:0] p6_ca, p6_sa;
  logic          p6_sx, p6_sy, p6_sz;

  always_ff @(posedge clk) begin
    if (en) begin
      p6_cl <= p5_r[31:0] * s5_cb;
      p6_ch <= p5_r[63:32] * s5_cb;
      p6_sl <= p5_r[31:0] * s5_sb;
      p6_sh <= p5_r[63:32] * s5_sb;
      p6_ca <= s5_ca;
      p6_sa <= s5_sa;
      p6_sx <= s5_sx;
      p6_sy <= s5_sy;
      p6_sz <= s5_sz;
    end
  end

  // ---------------- P7: H and |z| with rounding ----------------
  logic [95:0] hc_sum, zs_sum;
  logic [64:0] h_full;

  always_comb begin
    hc_sum = (96'(p6_ch) << 32) + 96'(p6_cl) + (96'd1 << 29);
    zs_sum = (96'(p6_sh) << 32) + 96'(p6_sl) + (96'd1 << 45);
    h_full = hc_sum[94:30];
  end

  logic          p7_valid;
  logic [63:0]   p7_h;
  logic [49:0]   p7_zm;
  logic [MW-1:0] p7_ca, p7_sa;
  logic          p7_sx, p7_sy, p7_sz;

  always_ff @(posedge clk) begin
    if (en) begin
      p7_h  <= h_full[64] ? '1 : h_full[63:0];
      p7_zm <= zs_sum[95:46];
      p7_ca <= p6_ca;
      p7_sa <= p6_sa;
      p7_sx <= p6_sx;
      p7_sy <= p6_sy;
      p7_sz <= p6_sz;
    end
  end

  // ---------------- P8: H*|cosA| and H*|sinA| partial products ----------------
  logic        p8_valid;
  logic [62:0] p8_xl, p8_xh, p8_yl, p8_yh;
  logic [49:0] p8_zm;
  logic        p8_sx, p8_sy, p8_sz;

  always_ff @(posedge clk) begin
    if (en) begin
      p8_xl <= p7_h[31:0] * p7_ca;
      p8_xh <= p7_h[63:32] * p7_ca;
      p8_yl <= p7_h[31:0] * p7_sa;
      p8_yh <= p7_h[63:32] * p7_sa;
      p8_zm <= p7_zm;
      p8_sx <= p7_sx;
      p8_sy <= p7_sy;
      p8_sz <= p7_sz;
    end
  end

  // ---------------- P9: round, sign and saturate ----------------
  function automatic logic [33:0] to_field(input logic [49:0] m, input logic neg);
    logic [33:0] f;
    if (m[49:33] != '0) f = neg ? 34'h2_0000_0000 : 34'h1_FFFF_FFFF;
    else f = neg ? (34'd0 - m[33:0]) : m[33:0];
    return f;
  endfunction

  logic [95:0]  x_sum, y_sum;
  logic [101:0] lst_data;

  always_comb begin
    x_sum = (96'(p8_xh) << 32) + 96'(p8_xl) + (96'd1 << 45);
    y_sum = (96'(p8_yh) << 32) + 96'(p8_yl) + (96'd1 << 45);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_data <= {to_field(p8_zm, p8_sz), to_field(y_sum[95:46], p8_sy),
                   to_field(x_sum[95:46], p8_sx)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid  <= 1'b0;
      p6_valid  <= 1'b0;
      p7_valid  <= 1'b0;
      p8_valid  <= 1'b0;
      lst_valid <= 1'b0;
    end else if (en) begin
      p5_valid  <= dv[esp_pkg::DIV_STEPS];
      p6_valid  <= p5_valid;
      p7_valid  <= p6_valid;
      p8_valid  <= p7_valid;
      lst_valid <= p8_valid;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= lst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= {2'b00, lst_data};
    end
  end

  // ---------------- assertions ----------------
  // input stalls only because a result is held back at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // equatorial register takes the written value
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[3] == esp_pkg::REG_EQUATORIAL) |=>
      (equatorial == $past(pwdata[RW-1:0])))
    else $error("equatorial radius write lost");

  // zero divisor yields zero radius
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (en && dv[esp_pkg::DIV_STEPS] && dq.den == '0) |=> (p5_r == '0))
    else $error("zero divisor did not give zero radius");

  // nothing leaves right after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
